// ===== design/ngs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngs_pkg
// Shared types and constants for the nearest entity gap selector.
// ----------------------------------------------------------------------------
package ngs_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned IndexW = 8;
  localparam int unsigned GapW   = 31;
  // Only bits 43..12 of the squared sums reach the result.
  localparam int unsigned SqW    = 44;
  localparam int unsigned FracW  = 12;
  localparam int unsigned AddrW  = 4;

  localparam logic [SqW-1:0]  RoundHalf = 44'h000_0000_0800;
  localparam logic [GapW-1:0] GapInit   = 31'h7FFF_FFFF;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_REF_X      = 2'd0,
    REG_REF_Y      = 2'd1,
    REG_REF_Z      = 2'd2,
    REG_REF_RADIUS = 2'd3
  } ngs_reg_t;

  typedef struct packed {
    logic [CoordW-1:0] ref_x;
    logic [CoordW-1:0] ref_y;
    logic [CoordW-1:0] ref_z;
    logic [CoordW-1:0] ref_radius;
  } ngs_cfg_t;

  // Control fields that ride along with each word through the pipe.
  typedef struct packed {
    logic [IndexW-1:0] index;
    logic              eligible;
    logic              last;
  } ngs_tag_t;

  typedef struct packed {
    ngs_tag_t          tag;
    logic [GapW-1:0]   gap;
  } ngs_gap_word_t;

endpackage

// ===== design/ngs_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngs_cfg_regs
// APB-style register file holding the reference position and radius.
// ----------------------------------------------------------------------------
module ngs_cfg_regs (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ngs_pkg::AddrW-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  output ngs_pkg::ngs_cfg_t        cfg
);
  import ngs_pkg::*;

  ngs_reg_t reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = ngs_reg_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_REF_X:      cfg.ref_x      <= pwdata;
        REG_REF_Y:      cfg.ref_y      <= pwdata;
        REG_REF_Z:      cfg.ref_z      <= pwdata;
        REG_REF_RADIUS: cfg.ref_radius <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_REF_X:      prdata = cfg.ref_x;
      REG_REF_Y:      prdata = cfg.ref_y;
      REG_REF_Z:      prdata = cfg.ref_z;
      REG_REF_RADIUS: prdata = cfg.ref_radius;
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== design/ngs_gap_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngs_gap_pipe
// Five-stage pipe: input register, deltas, squares, rounded sums, clamped gap.
// ----------------------------------------------------------------------------
module ngs_gap_pipe (
  input  logic                        clk,
  input  logic                        rst,
  input  ngs_pkg::ngs_cfg_t           cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ngs_pkg::IndexW-1:0]  entity_index,
  input  logic [ngs_pkg::CoordW-1:0]  pos_x,
  input  logic [ngs_pkg::CoordW-1:0]  pos_y,
  input  logic [ngs_pkg::CoordW-1:0]  pos_z,
  input  logic [ngs_pkg::CoordW-1:0]  radius,
  input  logic                        is_active,
  input  logic                        is_enabled,
  input  logic                        last_entity,
  output logic                        gap_valid,
  input  logic                        gap_ready,
  output ngs_pkg::ngs_gap_word_t      gap_word
);
  import ngs_pkg::*;

  // stage 1: input register
  logic              v1;
  ngs_tag_t          tag1;
  logic [CoordW-1:0] px1, py1, pz1, rad1;
  // stage 2: deltas
  logic              v2;
  ngs_tag_t          tag2;
  logic [CoordW-1:0] dx2, dy2, dz2, rad2;
  // stage 3: squares, low bits only
  logic              v3;
  ngs_tag_t          tag3;
  logic [SqW-1:0]    sqx3, sqy3, sqz3, sqr3, sqe3;
  // stage 4: rounded sums
  logic              v4;
  ngs_tag_t          tag4;
  logic [CoordW-1:0] dist4, rsq4;
  // stage 5: clamped gap
  logic              v5;

  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  logic signed [63:0] sqx_full, sqy_full, sqz_full, sqr_full, sqe_full;
  logic [SqW-1:0]     dist_sum, rsq_sum;
  logic [CoordW-1:0]  diff4;

  // A stage takes a new word when it is empty or its word moves on.
  assign rdy5     = !v5 || gap_ready;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;
  assign gap_valid = v5;

  assign sqx_full = $signed(dx2) * $signed(dx2);
  assign sqy_full = $signed(dy2) * $signed(dy2);
  assign sqz_full = $signed(dz2) * $signed(dz2);
  assign sqr_full = $signed(cfg.ref_radius) * $signed(cfg.ref_radius);
  assign sqe_full = $signed(rad2) * $signed(rad2);

  assign dist_sum = sqx3 + sqy3 + sqz3 + RoundHalf;
  assign rsq_sum  = sqr3 + sqe3 + RoundHalf;
  assign diff4    = dist4 - rsq4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      tag1.index    <= entity_index;
      tag1.eligible <= is_active && is_enabled;
      tag1.last     <= last_entity;
      px1  <= pos_x;
      py1  <= pos_y;
      pz1  <= pos_z;
      rad1 <= radius;
    end
    if (rdy2) begin
      tag2 <= tag1;
      dx2  <= px1 - cfg.ref_x;
      dy2  <= py1 - cfg.ref_y;
      dz2  <= pz1 - cfg.ref_z;
      rad2 <= rad1;
    end
    if (rdy3) begin
      tag3 <= tag2;
      sqx3 <= sqx_full[SqW-1:0];
      sqy3 <= sqy_full[SqW-1:0];
      sqz3 <= sqz_full[SqW-1:0];
      sqr3 <= sqr_full[SqW-1:0];
      sqe3 <= sqe_full[SqW-1:0];
    end
    if (rdy4) begin
      tag4  <= tag3;
      dist4 <= dist_sum[SqW-1:FracW];
      rsq4  <= rsq_sum[SqW-1:FracW];
    end
    if (rdy5) begin
      gap_word.tag <= tag4;
      // clamp a negative gap to zero
      gap_word.gap <= diff4[CoordW-1] ? '0 : diff4[GapW-1:0];
    end
  end

endmodule

// ===== design/ngs_min_track.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngs_min_track
// Running minimum of the gap over a scan, with the result register.
// ----------------------------------------------------------------------------
module ngs_min_track (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        gap_valid,
  output logic                        gap_ready,
  input  ngs_pkg::ngs_gap_word_t      gap_word,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        found,
  output logic [ngs_pkg::IndexW-1:0]  best_index,
  output logic [ngs_pkg::GapW-1:0]    best_gap
);
  import ngs_pkg::*;

  logic              have_best;
  logic [IndexW-1:0] best_so_far_index;
  logic [GapW-1:0]   best_so_far_gap;

  logic              take;
  logic              better;
  logic              have_next;
  logic [IndexW-1:0] index_next;
  logic [GapW-1:0]   gap_next;

  // A closing word waits only while an earlier result is still held.
  assign gap_ready = !gap_word.tag.last || !out_valid || out_ready;
  assign take      = gap_valid && gap_ready;

  // Strict compare: ties keep the earlier entity.
  assign better     = gap_word.tag.eligible && (gap_word.gap < best_so_far_gap);
  assign have_next  = have_best || better;
  assign index_next = better ? gap_word.tag.index : best_so_far_index;
  assign gap_next   = better ? gap_word.gap : best_so_far_gap;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_best         <= 1'b0;
      best_so_far_index <= '0;
      best_so_far_gap   <= GapInit;
      out_valid         <= 1'b0;
    end else begin
      if (take && gap_word.tag.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        if (gap_word.tag.last) begin
          have_best         <= 1'b0;
          best_so_far_index <= '0;
          best_so_far_gap   <= GapInit;
        end else begin
          have_best         <= have_next;
          best_so_far_index <= index_next;
          best_so_far_gap   <= gap_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && gap_word.tag.last) begin
      found      <= have_next;
      best_index <= have_next ? index_next : '0;
      best_gap   <= have_next ? gap_next : '0;
    end
  end

endmodule

// ===== design/nearest_entity_gap_select.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_entity_gap_select
// Streaming nearest-entity search by clamped squared gap.
// ----------------------------------------------------------------------------
// Accepts one entity word per clock while in_ready is high. Each word passes
// a five-stage pipe (input register, deltas, 32x32 squares, rounded sums,
// clamped gap) and then the running-minimum stage, which loads the result of
// a scan into the output register when it takes the last entity word. A
// result waits in that register until taken; entity words keep flowing
// meanwhile, and only a further last-entity word reaching the minimum stage
// stalls the pipe while the previous result is still held. Reference position
// and radius must only be written while no scan is in flight.
// ----------------------------------------------------------------------------
module nearest_entity_gap_select (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ngs_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ngs_pkg::IndexW-1:0]  entity_index,
  input  logic signed [ngs_pkg::CoordW-1:0] pos_x,
  input  logic signed [ngs_pkg::CoordW-1:0] pos_y,
  input  logic signed [ngs_pkg::CoordW-1:0] pos_z,
  input  logic signed [ngs_pkg::CoordW-1:0] radius,
  input  logic                        is_active,
  input  logic                        is_enabled,
  input  logic                        last_entity,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        found,
  output logic [ngs_pkg::IndexW-1:0]  best_index,
  output logic [ngs_pkg::GapW-1:0]    best_gap
);
  import ngs_pkg::*;

  ngs_cfg_t      cfg;
  logic          gap_valid;
  logic          gap_ready;
  ngs_gap_word_t gap_word;

  ngs_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ngs_gap_pipe u_pipe (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .entity_index (entity_index),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .radius       (radius),
    .is_active    (is_active),
    .is_enabled   (is_enabled),
    .last_entity  (last_entity),
    .gap_valid    (gap_valid),
    .gap_ready    (gap_ready),
    .gap_word     (gap_word)
  );

  ngs_min_track u_track (
    .clk        (clk),
    .rst        (rst),
    .gap_valid  (gap_valid),
    .gap_ready  (gap_ready),
    .gap_word   (gap_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .found      (found),
    .best_index (best_index),
    .best_gap   (best_gap)
  );

endmodule
